[rtl/uftt_pkg.sv]
// Shared types, constants and the bucket hash of the UDP flow table tracker.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps

package uftt_pkg;

   localparam int SLOTS_DEF     = 64;
   localparam int BUCKETS_DEF   = 128;
   localparam int UDP_HDR_BYTES = 8;
   localparam int REQ_BITS      = 136;
   localparam int RSP_BITS      = 96;
   localparam logic [5:0] THR_RESET = 6'd48;
   localparam logic [1:0] ADDR_EVICT_THR = 2'd0;

   typedef struct packed {
      logic [15:0] udp_len;
      logic [15:0] ip_total_len;
      logic [3:0]  ip_header_words;
      logic [15:0] dst_port;
      logic [15:0] src_port;
      logic [31:0] dst_addr;
      logic [31:0] src_addr;
   } req_type;

   typedef struct packed {
      logic [31:0] server_bytes;
      logic [31:0] client_bytes;
      logic [5:0]  evicted_slot;
      logic        evicted;
      logic [15:0] payload_len;
      logic        client_dir;
      logic        is_new;
      logic [5:0]  flow_slot;
      logic        accepted;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_BUCKET, ST_SLOT, ST_MISS, ST_HIT, ST_DECIDE,
      ST_EV_AGE, ST_EV_KEY, ST_EV_HEAD, ST_EV_WALK, ST_EV_FREE, ST_POP,
      ST_INSERT, ST_RESP
   } state_type;

   typedef struct packed {
      logic load_in;
      logic bkt_rd;
      logic key_victim;
      logic key_fwd;
      logic set_rev;
      logic cur_head;
      logic cur_link;
      logic hit_upd;
      logic drop_res;
      logic victim_latch;
      logic head_unlink;
      logic link_unlink;
      logic push_free;
      logic insert;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic rev;
      logic head_none;
      logic match;
      logic link_none;
      logic need_evict;
      logic head_is_victim;
      logic link_is_victim;
      logic count_zero;
      logic out_free;
   } sts_type;

   // xor fold of the 96-bit tuple with a little mixing
   function automatic logic [15:0] hash16(input logic [95:0] k);
      logic [15:0] h;
      h = k[15:0] ^ k[31:16] ^ k[47:32] ^ k[63:48] ^ k[79:64] ^ k[95:80];
      h = h ^ {h[6:0], h[15:7]} ^ {h[10:0], h[15:11]};
      return h;
   endfunction

endpackage

[rtl/uftt_ctrl.sv]
// Sequencer of the flow tracker: lookup, eviction and insert steps.
// Depends on uftt_pkg; drives uftt_dp through cmd_type, reads sts_type.
`timescale 1ns / 1ps

module uftt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  uftt_pkg::sts_type sts,
   output uftt_pkg::cmd_type cmd
);

   uftt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uftt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         uftt_pkg::ST_IDLE:    if (req_tvalid) state_in = uftt_pkg::ST_CHECK;
         uftt_pkg::ST_CHECK:   state_in = sts.drop ? uftt_pkg::ST_RESP : uftt_pkg::ST_BUCKET;
         uftt_pkg::ST_BUCKET:  state_in = sts.head_none ? uftt_pkg::ST_MISS : uftt_pkg::ST_SLOT;
         uftt_pkg::ST_SLOT: begin
            if (sts.match) state_in = uftt_pkg::ST_HIT;
            else if (sts.link_none) state_in = uftt_pkg::ST_MISS;
         end
         uftt_pkg::ST_MISS:    state_in = sts.rev ? uftt_pkg::ST_DECIDE : uftt_pkg::ST_CHECK;
         uftt_pkg::ST_HIT:     state_in = uftt_pkg::ST_RESP;
         uftt_pkg::ST_DECIDE:  state_in = sts.need_evict ? uftt_pkg::ST_EV_AGE : uftt_pkg::ST_POP;
         uftt_pkg::ST_EV_AGE:  state_in = uftt_pkg::ST_EV_KEY;
         uftt_pkg::ST_EV_KEY:  state_in = uftt_pkg::ST_EV_HEAD;
         uftt_pkg::ST_EV_HEAD: state_in = sts.head_is_victim ? uftt_pkg::ST_EV_FREE
                                                             : uftt_pkg::ST_EV_WALK;
         uftt_pkg::ST_EV_WALK: begin
            if (sts.link_is_victim || sts.link_none) state_in = uftt_pkg::ST_EV_FREE;
         end
         uftt_pkg::ST_EV_FREE: state_in = uftt_pkg::ST_POP;
         uftt_pkg::ST_POP:     state_in = uftt_pkg::ST_INSERT;
         uftt_pkg::ST_INSERT:  state_in = uftt_pkg::ST_RESP;
         uftt_pkg::ST_RESP:    if (sts.out_free) state_in = uftt_pkg::ST_IDLE;
         default:              state_in = uftt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         uftt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load_in = req_tvalid;
         end
         uftt_pkg::ST_CHECK: begin
            cmd.bkt_rd = 1'b1;
            cmd.drop_res = sts.drop;
         end
         uftt_pkg::ST_BUCKET:  cmd.cur_head = 1'b1;
         uftt_pkg::ST_SLOT:    cmd.cur_link = !sts.match;
         uftt_pkg::ST_MISS:    cmd.set_rev = !sts.rev;
         uftt_pkg::ST_HIT:     cmd.hit_upd = 1'b1;
         uftt_pkg::ST_EV_AGE:  cmd.victim_latch = 1'b1;
         uftt_pkg::ST_EV_KEY: begin
            cmd.bkt_rd = 1'b1;
            cmd.key_victim = 1'b1;
         end
         uftt_pkg::ST_EV_HEAD: begin
            cmd.head_unlink = sts.head_is_victim;
            cmd.cur_head = !sts.head_is_victim;
         end
         uftt_pkg::ST_EV_WALK: begin
            cmd.link_unlink = sts.link_is_victim;
            cmd.cur_link = !sts.link_is_victim;
         end
         uftt_pkg::ST_EV_FREE: cmd.push_free = 1'b1;
         uftt_pkg::ST_POP: begin
            cmd.bkt_rd = 1'b1;
            cmd.key_fwd = 1'b1;
         end
         uftt_pkg::ST_INSERT:  cmd.insert = 1'b1;
         uftt_pkg::ST_RESP:    cmd.out_load = sts.out_free;
         default: ;
      endcase
   end

endmodule

[rtl/uftt_dp.sv]
// Datapath of the flow tracker: request registers, flow memories, free stack,
// age ring, counters and the result register. Depends on uftt_pkg.
`timescale 1ns / 1ps

module uftt_dp #(
   parameter int SLOTS   = uftt_pkg::SLOTS_DEF,
   parameter int BUCKETS = uftt_pkg::BUCKETS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  uftt_pkg::req_type req_in,
   input  logic [5:0]        evict_thr,
   input  uftt_pkg::cmd_type cmd,
   output uftt_pkg::sts_type sts,
   output uftt_pkg::rsp_type rsp_out,
   output logic              rsp_tvalid,
   input  logic              rsp_tready
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = SW + 1;
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam logic [PW-1:0] NONE = PW'(SLOTS);
   localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

   // memories
   logic [95:0]   key_mem  [SLOTS];
   logic [PW-1:0] link_mem [SLOTS];
   logic [63:0]   cnt_mem  [SLOTS];
   logic [PW-1:0] bhead_mem[BUCKETS];
   logic [SW-1:0] age_mem  [SLOTS];
   logic [SW-1:0] free_mem [SLOTS];
   logic [BUCKETS-1:0] bvalid_ff;
   logic [SLOTS-1:0]   fvalid_ff;

   uftt_pkg::req_type req_ff;
   uftt_pkg::rsp_type res_ff, res_in, rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rev_ff;
   logic [PW-1:0]     cur_ff, cur_in;
   logic [SW-1:0]     victim_ff;
   logic [PW-1:0]     vlink_ff;
   logic              ev_ff;
   logic [BW-1:0]     bidx_ff, bidx_in;
   logic [SW-1:0]     age_head_ff, age_tail_ff;
   logic [PW-1:0]     free_top_ff, flow_cnt_ff;

   logic [95:0]   key_rd_ff;
   logic [PW-1:0] link_rd_ff;
   logic [63:0]   cnt_rd_ff;
   logic [PW-1:0] bhead_rd_ff;
   logic          bvalid_rd_ff;
   logic [SW-1:0] age_rd_ff;
   logic [SW-1:0] free_rd_ff;
   logic          fvalid_rd_ff;

   logic [95:0]   fwd_key, rev_key, look_key, hash_key;
   logic [15:0]   hash_val;
   logic [PW-1:0] head_eff, slot_ra, ft_m1;
   logic [SW-1:0] new_slot, victim_sel;
   logic signed [17:0] ip_pay;
   logic [31:0]   sum;

   assign fwd_key  = {req_ff.src_addr, req_ff.dst_addr, req_ff.src_port, req_ff.dst_port};
   assign rev_key  = {req_ff.dst_addr, req_ff.src_addr, req_ff.dst_port, req_ff.src_port};
   assign look_key = rev_ff ? rev_key : fwd_key;
   assign hash_key = cmd.key_victim ? key_rd_ff : (cmd.key_fwd ? fwd_key : look_key);
   assign hash_val = uftt_pkg::hash16(hash_key);
   assign bidx_in  = BW'((32'(hash_val) * 32'(BUCKETS)) >> 16);
   assign head_eff = bvalid_rd_ff ? bhead_rd_ff : NONE;
   assign victim_sel = age_rd_ff;
   assign ft_m1    = free_top_ff - PW'(1);
   assign new_slot = fvalid_rd_ff ? free_rd_ff : (LAST - ft_m1[SW-1:0]);

   assign ip_pay = $signed({2'b00, req_ff.ip_total_len})
                 - $signed({12'b0, req_ff.ip_header_words, 2'b00});

   always_comb begin
      cur_in = cur_ff;
      if (cmd.cur_head) cur_in = head_eff;
      else if (cmd.cur_link) cur_in = link_rd_ff;
      slot_ra = cur_in;
      if (cmd.victim_latch) slot_ra = {1'b0, victim_sel};
   end

   always_comb begin
      sts.drop = (ip_pay < 18'sd8) || (ip_pay < $signed({2'b00, req_ff.udp_len}))
               || (req_ff.udp_len < 16'(uftt_pkg::UDP_HDR_BYTES));
      sts.rev = rev_ff;
      sts.head_none = (head_eff >= NONE);
      sts.match = (key_rd_ff == look_key);
      sts.link_none = (link_rd_ff >= NONE);
      sts.need_evict = ((16'(flow_cnt_ff) > 16'(evict_thr)) || (free_top_ff == '0))
                     && (flow_cnt_ff != '0);
      sts.head_is_victim = (head_eff == {1'b0, victim_ff});
      sts.link_is_victim = (link_rd_ff == {1'b0, victim_ff});
      sts.count_zero = (flow_cnt_ff == '0);
      sts.out_free = !rsp_valid_ff || rsp_tready;
   end

   assign sum = (rev_ff ? cnt_rd_ff[63:32] : cnt_rd_ff[31:0]) + 32'(req_ff.ip_total_len);

   always_comb begin
      res_in = res_ff;
      if (cmd.drop_res) res_in = '0;
      if (cmd.hit_upd || cmd.insert) begin
         res_in.accepted = 1'b1;
         res_in.payload_len = req_ff.udp_len - 16'(uftt_pkg::UDP_HDR_BYTES);
         res_in.evicted = ev_ff;
         res_in.evicted_slot = ev_ff ? 6'(victim_ff) : 6'd0;
      end
      if (cmd.hit_upd) begin
         res_in.flow_slot = 6'(cur_ff);
         res_in.is_new = 1'b0;
         res_in.client_dir = !rev_ff;
         res_in.client_bytes = rev_ff ? sum : cnt_rd_ff[63:32];
         res_in.server_bytes = rev_ff ? cnt_rd_ff[31:0] : sum;
      end
      if (cmd.insert) begin
         res_in.flow_slot = 6'(new_slot);
         res_in.is_new = 1'b1;
         res_in.client_dir = 1'b1;
         res_in.client_bytes = '0;
         res_in.server_bytes = 32'(req_ff.ip_total_len);
      end
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // flow slot memories
   always_ff @(posedge clock) begin
      key_rd_ff  <= key_mem[slot_ra[SW-1:0]];
      link_rd_ff <= link_mem[slot_ra[SW-1:0]];
      cnt_rd_ff  <= cnt_mem[slot_ra[SW-1:0]];
      if (cmd.insert) begin
         key_mem[new_slot]  <= fwd_key;
         link_mem[new_slot] <= head_eff;
         cnt_mem[new_slot]  <= {32'd0, 32'(req_ff.ip_total_len)};
      end
      if (cmd.hit_upd) begin
         cnt_mem[cur_ff[SW-1:0]] <= rev_ff ? {sum, cnt_rd_ff[31:0]} : {cnt_rd_ff[63:32], sum};
      end
      if (cmd.link_unlink) link_mem[cur_ff[SW-1:0]] <= vlink_ff;
   end

   // bucket heads; an entry without its valid bit is an empty chain
   always_ff @(posedge clock) begin
      bhead_rd_ff <= bhead_mem[bidx_in];
      if (cmd.head_unlink) bhead_mem[bidx_ff] <= vlink_ff;
      if (cmd.insert) bhead_mem[bidx_ff] <= {1'b0, new_slot};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff <= '0;
         bvalid_rd_ff <= 1'b0;
      end else begin
         bvalid_rd_ff <= bvalid_ff[bidx_in];
         if (cmd.head_unlink || cmd.insert) bvalid_ff[bidx_ff] <= 1'b1;
      end
   end

   // age ring and free stack
   always_ff @(posedge clock) begin
      age_rd_ff <= age_mem[age_head_ff];
      if (cmd.insert) age_mem[age_tail_ff] <= new_slot;
      free_rd_ff <= free_mem[ft_m1[SW-1:0]];
      if (cmd.push_free && (free_top_ff < PW'(SLOTS))) begin
         free_mem[free_top_ff[SW-1:0]] <= victim_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff    <= '0;
         fvalid_rd_ff <= 1'b0;
         age_head_ff  <= '0;
         age_tail_ff  <= '0;
         free_top_ff  <= PW'(SLOTS);
         flow_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rev_ff       <= 1'b0;
         ev_ff        <= 1'b0;
      end else begin
         fvalid_rd_ff <= fvalid_ff[ft_m1[SW-1:0]];
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load_in) begin
            rev_ff <= 1'b0;
            ev_ff <= 1'b0;
         end
         if (cmd.set_rev) rev_ff <= 1'b1;
         if (cmd.victim_latch) begin
            ev_ff <= 1'b1;
            age_head_ff <= (age_head_ff == LAST) ? '0 : age_head_ff + SW'(1);
         end
         if (cmd.push_free) begin
            flow_cnt_ff <= flow_cnt_ff - PW'(1);
            if (free_top_ff < PW'(SLOTS)) begin
               fvalid_ff[free_top_ff[SW-1:0]] <= 1'b1;
               free_top_ff <= free_top_ff + PW'(1);
            end
         end
         if (cmd.insert) begin
            free_top_ff <= ft_m1;
            flow_cnt_ff <= flow_cnt_ff + PW'(1);
            age_tail_ff <= (age_tail_ff == LAST) ? '0 : age_tail_ff + SW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) req_ff <= req_in;
      cur_ff <= cur_in;
      if (cmd.victim_latch) victim_ff <= victim_sel;
      if (cmd.victim_latch || cmd.bkt_rd) begin
         if (cmd.bkt_rd) bidx_ff <= bidx_in;
      end
      if (cmd.bkt_rd && cmd.key_victim) vlink_ff <= link_rd_ff;
      res_ff <= res_in;
      if (cmd.out_load) rsp_ff <= res_ff;
   end

   assign rsp_out = rsp_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/udp_flow_table_tracker_core.sv]
// UDP flow table tracker, top level: stream ports, APB register, assertions.
// Depends on uftt_pkg, uftt_ctrl and uftt_dp.
`timescale 1ns / 1ps

// One request carries the header fields of one IPv4/UDP packet and yields one
// response. Requests are handled one at a time. A dropped packet goes straight
// to the response; a forward hit walks the forward chain, a reverse hit and a
// new flow walk the chains of both keys, and an eviction also walks the chain
// that holds the victim to unlink it. The chain walk is bounded by the single
// read port of each flow memory and visits one node per cycle. The response
// sits in an output register, so a new request is taken while it waits.
// evict_threshold is at byte address 0 and resets to 48. Bucket heads and
// free-stack entries carry valid bits cleared by reset, so no clearing pass
// is needed.
module udp_flow_table_tracker_core #(
   parameter int SLOTS   = uftt_pkg::SLOTS_DEF,
   parameter int BUCKETS = uftt_pkg::BUCKETS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // src_addr, dst_addr, src_port, dst_port, ip_header_words, ip_total_len,
   // udp_len, zero pad
   input  logic [uftt_pkg::REQ_BITS-1:0] req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // accepted, flow_slot, is_new, client_dir, payload_len, evicted,
   // evicted_slot, client_bytes, server_bytes
   output logic [uftt_pkg::RSP_BITS-1:0] rsp_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [1:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   uftt_pkg::cmd_type cmd;
   uftt_pkg::sts_type sts;
   uftt_pkg::req_type req_in;
   uftt_pkg::rsp_type rsp_out;
   logic [5:0]        thr_ff;

   assign req_in = uftt_pkg::req_type'(req_tdata[131:0]);
   assign rsp_tdata = rsp_out;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == uftt_pkg::ADDR_EVICT_THR) ? {26'd0, thr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= uftt_pkg::THR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr == uftt_pkg::ADDR_EVICT_THR)) begin
         thr_ff <= csr_pwdata[5:0];
      end
   end

   uftt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   uftt_dp #(
      .SLOTS   (SLOTS),
      .BUCKETS (BUCKETS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_in     (req_in),
      .evict_thr  (thr_ff),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_out    (rsp_out),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a request is in flight");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("response load did not raise valid");

   a_free_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.push_free |-> !sts.count_zero)
      else $error("eviction with no flow held");

endmodule

[dv/tb.sv]
// Testbench for udp_flow_table_tracker_core: queue-fed stream driver, response monitor,
// a flow table predictor, and APB writes of evict_threshold between phases.
// Depends on uftt_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb;

   localparam int NSLOT = 64;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;

   logic                          clock;
   logic                          reset;
   logic [uftt_pkg::REQ_BITS-1:0] req_tdata;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [uftt_pkg::RSP_BITS-1:0] rsp_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [1:0]                    csr_paddr;
   logic [31:0]                   csr_pwdata;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   udp_flow_table_tracker_core i_dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predicted flow table
   bit          flow_live [NSLOT];
   logic [63:0] flow_addrs [NSLOT];
   logic [31:0] flow_ports [NSLOT];
   logic [31:0] flow_cbytes [NSLOT];
   logic [31:0] flow_sbytes [NSLOT];
   int          free_slots [NSLOT];
   int          free_top;
   int          age_order [$];
   int          live_flows;
   int          evict_thr;

   uftt_pkg::req_type pending_reqs [$];
   uftt_pkg::rsp_type expected_rsps [$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          errors;
   int          quiet_cycles;

   // pool of tuples so that lookups hit
   logic [31:0] pool_sa [96];
   logic [31:0] pool_da [96];
   logic [15:0] pool_sp [96];
   logic [15:0] pool_dp [96];

   function automatic uftt_pkg::rsp_type predict_flow(uftt_pkg::req_type r);
      uftt_pkg::rsp_type o;
      int          hl, tl, ul, pl, slot, victim;
      bit          fwd;
      logic [63:0] fa, ra;
      logic [31:0] fp, rp;
      o = '0;
      hl = int'(r.ip_header_words) * 4;
      tl = int'(r.ip_total_len);
      ul = int'(r.udp_len);
      pl = tl - hl;
      if (pl < uftt_pkg::UDP_HDR_BYTES || pl < ul || ul < uftt_pkg::UDP_HDR_BYTES) return o;
      fa = {r.src_addr, r.dst_addr};
      fp = {r.src_port, r.dst_port};
      ra = {r.dst_addr, r.src_addr};
      rp = {r.dst_port, r.src_port};
      slot = -1;
      fwd = 1'b1;
      for (int i = 0; i < NSLOT; i++)
         if (flow_live[i] && flow_addrs[i] == fa && flow_ports[i] == fp) slot = i;
      if (slot < 0)
         for (int i = 0; i < NSLOT; i++)
            if (flow_live[i] && flow_addrs[i] == ra && flow_ports[i] == rp) begin
               slot = i;
               fwd = 1'b0;
            end
      if (slot < 0) begin
         // at most one eviction, when the flow count exceeds the threshold or no slot is free
         if ((live_flows > evict_thr || free_top == 0) && live_flows > 0) begin
            victim = age_order.pop_front();
            flow_live[victim] = 1'b0;
            if (free_top < NSLOT) begin
               free_slots[free_top] = victim;
               free_top++;
            end
            live_flows--;
            o.evicted = 1'b1;
            o.evicted_slot = victim[5:0];
         end
         slot = free_slots[free_top - 1];
         free_top--;
         live_flows++;
         flow_live[slot] = 1'b1;
         flow_addrs[slot] = fa;
         flow_ports[slot] = fp;
         flow_cbytes[slot] = '0;
         flow_sbytes[slot] = '0;
         age_order.push_back(slot);
         o.is_new = 1'b1;
      end
      if (fwd) flow_sbytes[slot] += 32'(r.ip_total_len);
      else flow_cbytes[slot] += 32'(r.ip_total_len);
      o.accepted = 1'b1;
      o.flow_slot = slot[5:0];
      o.client_dir = fwd;
      o.payload_len = r.udp_len - 16'd8;
      o.client_bytes = flow_cbytes[slot];
      o.server_bytes = flow_sbytes[slot];
      return o;
   endfunction

   function automatic uftt_pkg::req_type mk_req(logic [31:0] sa, logic [31:0] da,
                                                logic [15:0] sp, logic [15:0] dp,
                                                logic [3:0] hw, logic [15:0] tl,
                                                logic [15:0] ul);
      uftt_pkg::req_type r;
      r.src_addr = sa;
      r.dst_addr = da;
      r.src_port = sp;
      r.dst_port = dp;
      r.ip_header_words = hw;
      r.ip_total_len = tl;
      r.udp_len = ul;
      return r;
   endfunction

   // packet on a pooled or fresh tuple, sometimes reversed, sometimes malformed or fully random
   function automatic uftt_pkg::req_type rand_req();
      int          k, hw, ul, tl;
      logic [31:0] sa, da;
      logic [15:0] sp, dp;
      if ($urandom_range(0, 9) == 0)
         return mk_req($urandom, $urandom, 16'($urandom), 16'($urandom), 4'($urandom),
                       16'($urandom), 16'($urandom));
      k = $urandom_range(0, 95);
      sa = pool_sa[k]; da = pool_da[k]; sp = pool_sp[k]; dp = pool_dp[k];
      if ($urandom_range(0, 9) == 0) begin
         sa = $urandom; da = $urandom; sp = 16'($urandom); dp = 16'($urandom);
      end
      hw = $urandom_range(0, 15);
      ul = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 65470) : $urandom_range(8, 1500);
      tl = hw * 4 + ul + $urandom_range(0, 4);
      if ($urandom_range(0, 19) == 0) tl = tl - 5;
      if ($urandom_range(0, 2) == 0)
         return mk_req(da, sa, dp, sp, 4'(hw), 16'(tl), 16'(ul));
      return mk_req(sa, da, sp, dp, 4'(hw), 16'(tl), 16'(ul));
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver; prediction happens on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) expected_rsps.push_back(predict_flow(req_tdata[131:0]));
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tdata <= {4'b0, pending_reqs.pop_front()};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // response monitor
   always @(posedge clock) begin
      uftt_pkg::rsp_type e, a;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            a = rsp_tdata;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               check_field("accepted", 32'(e.accepted), 32'(a.accepted));
               check_field("flow_slot", 32'(e.flow_slot), 32'(a.flow_slot));
               check_field("is_new", 32'(e.is_new), 32'(a.is_new));
               check_field("client_dir", 32'(e.client_dir), 32'(a.client_dir));
               check_field("payload_len", 32'(e.payload_len), 32'(a.payload_len));
               check_field("evicted", 32'(e.evicted), 32'(a.evicted));
               check_field("evicted_slot", 32'(e.evicted_slot), 32'(a.evicted_slot));
               check_field("client_bytes", e.client_bytes, a.client_bytes);
               check_field("server_bytes", e.server_bytes, a.server_bytes);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (expected_rsps.size() == 0 && !req_tvalid)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("udp_flow_table_tracker_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(int value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= uftt_pkg::ADDR_EVICT_THR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      evict_thr = value & 63;
      @(posedge clock);
   endtask

   initial begin
      int phase_thr [5];
      phase_thr = '{63, 5, 0, 48, 0};
      errors = 0;
      send_idle_pct = 37;
      recv_idle_pct = 68;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      for (int i = 0; i < NSLOT; i++) begin
         flow_live[i] = 1'b0;
         free_slots[i] = NSLOT - 1 - i;
      end
      free_top = NSLOT;
      live_flows = 0;
      evict_thr = int'(uftt_pkg::THR_RESET);
      for (int i = 0; i < 96; i++) begin
         pool_sa[i] = $urandom; pool_da[i] = $urandom;
         pool_sp[i] = 16'($urandom); pool_dp[i] = 16'($urandom);
      end
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: length limits, hits both ways, extremes
      pending_reqs.push_back(mk_req(0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req('1, '1, '1, '1, 4'hF, '1, '1));
      pending_reqs.push_back(mk_req('1, '1, '1, '1, 4'hF, '1, 16'd65475));
      pending_reqs.push_back(mk_req(1, 2, 3, 4, 5, 27, 8));
      pending_reqs.push_back(mk_req(1, 2, 3, 4, 5, 28, 8));
      pending_reqs.push_back(mk_req(1, 2, 3, 4, 5, 28, 7));
      pending_reqs.push_back(mk_req(1, 2, 3, 4, 5, 28, 9));
      pending_reqs.push_back(mk_req(1, 2, 3, 4, 0, 8, 8));
      pending_reqs.push_back(mk_req(2, 1, 4, 3, 0, 100, 50));
      pending_reqs.push_back(mk_req(1, 2, 3, 4, 0, 65535, 65535));
      pending_reqs.push_back(mk_req(2, 1, 4, 3, 0, 65535, 8));
      pending_reqs.push_back(mk_req('1, 0, '1, 0, 0, 7, 7));
      pending_reqs.push_back(mk_req(0, '1, 0, '1, 4'hF, 68, 8));
      pending_reqs.push_back(mk_req('1, 0, '1, 0, 4'hF, 68, 8));
      pending_reqs.push_back(mk_req(5, 5, 7, 7, 1, 20, 16));
      pending_reqs.push_back(mk_req(5, 5, 7, 7, 1, 20, 16));
      for (int i = 0; i < 200; i++) pending_reqs.push_back(rand_req());

      // each phase boundary drains everything before the register write
      for (int ph = 0; ph < 5; ph++) begin
         wait_idle();
         write_threshold(phase_thr[ph]);
         if (ph == 1) begin
            send_idle_pct = 68;
            recv_idle_pct = 37;
         end else if (ph == 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < 170; i++) pending_reqs.push_back(rand_req());
      end
      wait_idle();
      if (errors == 0) begin
         $display("udp_flow_table_tracker_core verification clean");
      end else begin
         $display("udp_flow_table_tracker_core verification failed");
      end
      $finish;
   end

endmodule

[udp_flow_table_tracker_core.f]
rtl/uftt_pkg.sv
rtl/uftt_ctrl.sv
rtl/uftt_dp.sv
rtl/udp_flow_table_tracker_core.sv
dv/tb.sv
